@@ src/spq_pkg.sv @@
// spq_pkg: shared types and constants of the sorted priority queue
// no dependencies

package spq_pkg;

   localparam int SPQ_DEPTH = 16;
   localparam int PRI_W     = 8;
   localparam int PAY_W     = 32;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   typedef struct packed {
      logic [PRI_W-1:0] pri;
      logic [PAY_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic             enq;
      logic             deq;
      logic [PRI_W-1:0] pri;
      logic [PAY_W-1:0] payload;
   } cmd_type;

endpackage

@@ src/spq_cell.sv @@
// spq_cell: one slot of the sorted chain, holds an entry and shifts with its neighbours
// depends on spq_pkg

module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   input  logic      occupied,
   input  logic      left_stay,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output logic      stay,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   assign stay  = occupied && (entry_ff.pri <= cmd.pri);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq && !stay) begin
         if (left_stay) begin
            entry_in.pri     = cmd.pri;
            entry_in.payload = cmd.payload;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ src/sorted_priority_queue_top.sv @@
// sorted_priority_queue_top: stable min-first priority queue built as a chain of cells
// depends on spq_pkg and spq_cell
//
// An item is taken at any edge with start high; busy stays low, so one enqueue or dequeue
// is taken every cycle. The result of each item appears on the rsp_ ports, marked by
// rsp_valid, in the cycle after the item is taken, and lasts that one cycle only: the
// receiver cannot stall and must capture it then. Every cell compares its priority with
// the new one in parallel, whatever the fill level.

module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int DEPTH = SPQ_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_action,
   input  logic [PRI_W-1:0] req_item_priority,
   input  logic [PAY_W-1:0] req_item_payload,
   output logic             rsp_valid,
   output logic             rsp_out_valid,
   output logic [PRI_W-1:0] rsp_out_priority,
   output logic [PAY_W-1:0] rsp_out_payload,
   output logic             rsp_dropped,
   output logic             rsp_now_empty
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff;
   logic             out_valid_ff, out_valid_in;
   logic             dropped_ff, dropped_in;
   logic             now_empty_ff, now_empty_in;
   logic [PRI_W-1:0] out_pri_ff, out_pri_in;
   logic [PAY_W-1:0] out_pay_ff, out_pay_in;

   logic             full, empty;
   cmd_type          cmd;
   logic      [DEPTH-1:0] stay;
   entry_type [DEPTH-1:0] entry;

   assign busy  = 1'b0;
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.enq     = start && (req_action == ACT_ENQUEUE) && !full;
      cmd.deq     = start && (req_action == ACT_DEQUEUE) && !empty;
      cmd.pri     = req_item_priority;
      cmd.payload = req_item_payload;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      occ;
      logic      lstay;
      entry_type lent;
      entry_type rent;

      assign occ = (CW'(i) < count_ff);
      if (i == 0) begin : g_first
         assign lstay = 1'b1;
         assign lent  = entry[0];
      end else begin : g_mid
         assign lstay = stay[i-1];
         assign lent  = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rent = entry[i];
      end else begin : g_notlast
         assign rent = entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occ),
         .left_stay   (lstay),
         .left_entry  (lent),
         .right_entry (rent),
         .stay        (stay[i]),
         .entry       (entry[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      out_valid_in = 1'b0;
      out_pri_in   = '0;
      out_pay_in   = '0;
      dropped_in   = 1'b0;
      if (cmd.enq) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.deq) begin
         count_in     = count_ff - CW'(1);
         out_valid_in = 1'b1;
         out_pri_in   = entry[0].pri;
         out_pay_in   = entry[0].payload;
      end
      if (start && (req_action == ACT_ENQUEUE) && full) begin
         dropped_in = 1'b1;
      end
      now_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= start;
      end
      out_valid_ff <= out_valid_in;
      out_pri_ff   <= out_pri_in;
      out_pay_ff   <= out_pay_in;
      dropped_ff   <= dropped_in;
      now_empty_ff <= now_empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_priority = out_pri_ff;
   assign rsp_out_payload  = out_pay_ff;
   assign rsp_dropped      = dropped_ff;
   assign rsp_now_empty    = now_empty_ff;

endmodule
